// ===== hdl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Types and codes shared by the double-ended queue and its cell row.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic signed [WORD_W-1:0] word_t;

    // per-cycle move of a cell row
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_IN,
        OP_SHIFT_OUT,
        OP_APPEND,
        OP_DROP
    } row_op_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        word_t             value;
    } in_item_t;

    typedef struct packed {
        word_t               popped;
        word_t               front_word;
        word_t               back_word;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } out_item_t;

endpackage

// ===== hdl/deq_cell.sv =====
// ----------------------------------------------------------------------------
// deq_cell
// One slot of a cell row: holds a word and an occupied flag, and trades
// them with its neighbors as the row shifts, grows or shrinks.
// ----------------------------------------------------------------------------
module deq_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  deq_pkg::row_op_t op,
    input  deq_pkg::word_t  value,
    input  logic            left_valid,
    input  deq_pkg::word_t  left_data,
    input  logic            right_valid,
    input  deq_pkg::word_t  right_data,
    output logic            valid,
    output deq_pkg::word_t  data
);

    logic           valid_reg;
    logic           valid_next;
    deq_pkg::word_t data_reg;
    deq_pkg::word_t data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        unique case (op)
            deq_pkg::OP_SHIFT_IN:
            begin
                valid_next = left_valid;
                data_next  = left_data;
            end
            deq_pkg::OP_SHIFT_OUT:
            begin
                valid_next = right_valid;
                data_next  = right_data;
            end
            deq_pkg::OP_APPEND:
            begin
                // take the word if this is the first free slot
                if (!valid_reg && left_valid)
                begin
                    valid_next = 1'b1;
                    data_next  = value;
                end
            end
            deq_pkg::OP_DROP:
            begin
                // release the last occupied slot
                if (valid_reg && !right_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
                valid_next = valid_reg;
                data_next  = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== hdl/deq_chain.sv =====
// ----------------------------------------------------------------------------
// deq_chain
// A row of DEPTH cells kept packed against cell 0. The head word sits in
// cell 0; words enter or leave there by shifting, or at the far end of the
// occupied run by local append and drop.
// ----------------------------------------------------------------------------
module deq_chain
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  deq_pkg::row_op_t op,
    input  deq_pkg::word_t   value,
    output logic             head_valid,
    output deq_pkg::word_t   head_data
);

    logic           valid_w [DEPTH];
    deq_pkg::word_t data_w  [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic           lv;
        deq_pkg::word_t ld;
        logic           rv;
        deq_pkg::word_t rd;

        if (i == 0)
        begin : g_first
            assign lv = 1'b1;
            assign ld = value;
        end
        else
        begin : g_mid_l
            assign lv = valid_w[i-1];
            assign ld = data_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign rv = 1'b0;
            assign rd = data_w[i];
        end
        else
        begin : g_mid_r
            assign rv = valid_w[i+1];
            assign rd = data_w[i+1];
        end

        deq_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .value       (value),
            .left_valid  (lv),
            .left_data   (ld),
            .right_valid (rv),
            .right_data  (rd),
            .valid       (valid_w[i]),
            .data        (data_w[i])
        );
    end

    assign head_valid = valid_w[0];
    assign head_data  = data_w[0];

endmodule

// ===== hdl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Fixed-capacity double-ended queue of signed 32-bit words.
// ----------------------------------------------------------------------------
// An item is taken at every clock edge with start high (busy never rises),
// so one operation per cycle is sustained. Its result appears for exactly
// one cycle, marked by done, in the cycle after the item was taken; it must
// be captured then. The words live twice, in two rows of DEPTH cells: one
// row holds them front first and the other back first, so both ends sit in
// cell 0 of a row and every push or pop is a single shift, append or drop
// across the row. A push to a full queue or a pop from an empty queue
// changes nothing and reports it in status.
// ----------------------------------------------------------------------------
module double_ended_queue
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  deq_pkg::in_item_t  cmd,
    output logic               done,
    output deq_pkg::out_item_t result
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_next;
    logic                           done_reg;
    deq_pkg::word_t                 popped_reg;
    deq_pkg::word_t                 popped_next;
    logic [deq_pkg::STATUS_W-1:0]   status_reg;
    logic [deq_pkg::STATUS_W-1:0]   status_next;

    deq_pkg::row_op_t fwd_op;
    deq_pkg::row_op_t rev_op;
    logic             fwd_head_valid;
    deq_pkg::word_t   fwd_head_data;
    logic             rev_head_valid;
    deq_pkg::word_t   rev_head_data;

    logic accept;
    logic is_full;
    logic is_empty;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        fwd_op      = deq_pkg::OP_HOLD;
        rev_op      = deq_pkg::OP_HOLD;
        count_next  = count_reg;
        popped_next = '0;
        status_next = deq_pkg::ST_DONE;
        if (accept)
        begin
            unique case (cmd.kind)
                deq_pkg::KIND_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        fwd_op     = deq_pkg::OP_SHIFT_IN;
                        rev_op     = deq_pkg::OP_APPEND;
                        count_next = count_reg + CW'(1);
                    end
                end
                deq_pkg::KIND_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        fwd_op     = deq_pkg::OP_APPEND;
                        rev_op     = deq_pkg::OP_SHIFT_IN;
                        count_next = count_reg + CW'(1);
                    end
                end
                deq_pkg::KIND_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        fwd_op      = deq_pkg::OP_SHIFT_OUT;
                        rev_op      = deq_pkg::OP_DROP;
                        count_next  = count_reg - CW'(1);
                        popped_next = fwd_head_data;
                    end
                end
                deq_pkg::KIND_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        fwd_op      = deq_pkg::OP_DROP;
                        rev_op      = deq_pkg::OP_SHIFT_OUT;
                        count_next  = count_reg - CW'(1);
                        popped_next = rev_head_data;
                    end
                end
                default:
                begin
                    status_next = deq_pkg::ST_DONE;
                end
            endcase
        end
    end

    deq_chain #(.DEPTH(DEPTH)) u_fwd
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (fwd_op),
        .value      (cmd.value),
        .head_valid (fwd_head_valid),
        .head_data  (fwd_head_data)
    );

    deq_chain #(.DEPTH(DEPTH)) u_rev
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (rev_op),
        .value      (cmd.value),
        .head_valid (rev_head_valid),
        .head_data  (rev_head_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
    end

    assign done              = done_reg;
    assign result.popped     = popped_reg;
    assign result.front_word = is_empty ? '0 : fwd_head_data;
    assign result.back_word  = is_empty ? '0 : rev_head_data;
    assign result.count      = deq_pkg::COUNT_W'(count_reg);
    assign result.status     = status_reg;

    a_rows_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fwd_head_valid == !is_empty) && (rev_head_valid == !is_empty))
        else $error("cell rows disagree with word count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("word count beyond capacity");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("item taken without a result");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == deq_pkg::ST_FULL) |-> is_full)
        else $error("push rejected while not full");

    a_empty_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == deq_pkg::ST_EMPTY) |-> is_empty)
        else $error("pop rejected while not empty");

endmodule
